@@ rtl/core/rsem_pkg.sv @@
// Shared constants, codes and control types of the RGB Sobel edge magnitude block.
package rsem_pkg;

  // Line store depth; must be a power of two
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);

  // Fixed field widths
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 13;
  localparam int CFG_D_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 13;
  localparam int PIX_W     = 16;
  localparam int ABS_W     = 18;
  localparam int RAD_W     = 38;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_STEPS  = RAD_W / 2;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);

  // Luma weights, 0.299 / 0.587 / 0.114 in 16-bit fixed point
  localparam int GRAY_R = 19595;
  localparam int GRAY_G = 38470;
  localparam int GRAY_B = 7471;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic step;
    logic src_flush;
    logic repl;
    logic sq_x;
    logic sq_y;
    logic out_load;
    logic is_flush;
  } rsem_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pend_zero;
    logic emit;
    logic repl_case;
    logic sq_busy;
    logic slot_free;
  } rsem_status_t;

endpackage

@@ rtl/core/rgb_sobel_edge_magnitude.sv @@
// Top level of the RGB Sobel edge magnitude block: controller, datapath and checks.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_operation, in_red, in_green, in_blue
//  out     | output    | out_valid/out_stall | out_magnitude, out_last_of_frame
//  cfg     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// A transfer producing a result takes one window step, the two squaring states, the
// bit-serial square root, one output load and a return to idle. A flush may add up to two
// further window steps, each followed by a wait for the line store read. A pixel with no
// result takes only the window step; a dropped pixel or an ignored flush stays in idle.
// Reset is synchronous, active low; in_stall is high for the first cycle after it.
// One finished result waits in the output register while the next transfer is taken.
module rgb_sobel_edge_magnitude
  import rsem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_magnitude,
  output logic                 out_last_of_frame,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]   cfg_wdata
);

  rsem_cmd_t    cmd;
  rsem_status_t status;

  rsem_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  rsem_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_magnitude     (out_magnitude),
    .out_last_of_frame (out_last_of_frame)
  );

  // No transfer is taken while the root is still being worked out
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !status.sq_busy)
    else $error("input taken while square root busy");

  // A result is only loaded into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // Starting the root makes the unit busy in the next cycle
  a_root_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_y |=> status.sq_busy)
    else $error("square root did not start");

endmodule

@@ rtl/core/rsem_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rsem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/rsem_isqrt.sv @@
// Restoring integer square root, one result bit per cycle.
module rsem_isqrt
  import rsem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic                busy_r, busy_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [ROOT_W+2:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [ROOT_W+2:0]   shifted;
  logic [ROOT_W+2:0]   trial;

  // Bring down the next bit pair and try the trial subtrahend
  always_comb begin
    shifted  = {rem_r[ROOT_W:0], rad_r[RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(SQ_STEPS - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

@@ rtl/core/rsem_dp.sv @@
// Datapath: gray conversion, line stores, window, gradients, square root, output register.
module rsem_dp
  import rsem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsem_cmd_t            cmd,
  output rsem_status_t         status,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]   cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_magnitude,
  output logic                 out_last_of_frame
);

  logic [CFG_W_W-1:0] fw_r, fw_nxt;
  logic [CFG_H_W-1:0] fh_r, fh_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [7:0]         red_r, green_r, blue_r;
  logic [PIX_W-1:0]   win_r [9];
  logic [PIX_W-1:0]   win_nxt [9];
  logic [PIX_W-1:0]   mw [9];
  logic [ABS_W-1:0]   ax_r, ay_r;
  logic [RAD_W-1:0]   rad_r;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_mag_r;
  logic               out_last_r;

  logic [EW_W-1:0]    eff_w;
  logic [CFG_H_W-1:0] eff_h;
  logic [23:0]        gray_sum;
  logic [PIX_W-1:0]   gray, g_src, t_val, m_val;
  logic [PIX_W-1:0]   prev_rd, prev2_rd;
  logic               col_zero, col_end, row_end, pix_last;
  logic [ABS_W-1:0]   px, nx, py, ny;
  logic [2*ABS_W-1:0] ax_sq, ay_sq;
  logic [RAD_W-1:0]   sq_in;
  logic [ROOT_W-1:0]  root;
  logic               sq_busy;
  logic               wr_step;

  // Clamped frame size
  always_comb begin
    if (fw_r == '0) begin
      eff_w = EW_W'(1);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(fw_r);
    end
    if (fh_r == '0) begin
      eff_h = CFG_H_W'(1);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      eff_h = CFG_H_W'(MAX_HEIGHT);
    end else begin
      eff_h = fh_r;
    end
  end

  // Luma in 8.8
  assign gray_sum = 24'(GRAY_R) * 24'(red_r) + 24'(GRAY_G) * 24'(green_r)
                  + 24'(GRAY_B) * 24'(blue_r);
  assign gray     = gray_sum[23:8];

  // Line stores, addressed by the current column
  assign wr_step = cmd.step;

  rsem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk   (clk),
    .we    (wr_step),
    .waddr (col_r),
    .wdata (g_src),
    .raddr (col_r),
    .rdata (prev_rd)
  );

  rsem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev2 (
    .clk   (clk),
    .we    (wr_step),
    .waddr (col_r),
    .wdata (prev_rd),
    .raddr (col_r),
    .rdata (prev2_rd)
  );

  // Position flags
  assign col_zero = (col_r == '0);
  assign col_end  = ({1'b0, col_r} + 1'b1) >= eff_w;
  assign row_end  = ({1'b0, row_r} + 1'b1) >= {1'b0, eff_h};
  assign pix_last = row_end && col_end;

  // Column entering the window; top rows replicated at the frame top
  always_comb begin
    g_src = cmd.src_flush ? prev_rd : gray;
    if (row_r == '0) begin
      t_val = g_src;
      m_val = g_src;
    end else if (row_r == ROW_W'(1)) begin
      t_val = prev_rd;
      m_val = prev_rd;
    end else begin
      t_val = prev2_rd;
      m_val = prev_rd;
    end
  end

  // Window seen by the gradient, and next window content
  always_comb begin
    if (cmd.repl || col_zero) begin
      mw = '{win_r[1], win_r[2], win_r[2], win_r[4], win_r[5], win_r[5],
             win_r[7], win_r[8], win_r[8]};
    end else begin
      mw = '{win_r[1], win_r[2], t_val, win_r[4], win_r[5], m_val,
             win_r[7], win_r[8], g_src};
    end
    win_nxt = win_r;
    if (cmd.step) begin
      if (col_zero) begin
        win_nxt = '{t_val, t_val, t_val, m_val, m_val, m_val, g_src, g_src, g_src};
      end else begin
        win_nxt = mw;
      end
    end else if (cmd.repl) begin
      win_nxt = mw;
    end
  end

  // Sobel partial sums, positive and negative taps
  assign px = ABS_W'(mw[2]) + {1'b0, mw[5], 1'b0} + ABS_W'(mw[8]);
  assign nx = ABS_W'(mw[0]) + {1'b0, mw[3], 1'b0} + ABS_W'(mw[6]);
  assign py = ABS_W'(mw[6]) + {1'b0, mw[7], 1'b0} + ABS_W'(mw[8]);
  assign ny = ABS_W'(mw[0]) + {1'b0, mw[1], 1'b0} + ABS_W'(mw[2]);

  // Squares of the gradient magnitudes, full product width
  assign ax_sq = ax_r * ax_r;
  assign ay_sq = ay_r * ay_r;

  assign sq_in = rad_r + RAD_W'(ay_sq);

  rsem_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sq_y),
    .radicand (sq_in),
    .busy     (sq_busy),
    .root     (root)
  );

  // Frame position, pending count and configuration
  always_comb begin
    fw_nxt   = fw_r;
    fh_nxt   = fh_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    priority if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_nxt = cfg_wdata[CFG_W_W-1:0];
        REG_FRAME_HEIGHT: fh_nxt = cfg_wdata[CFG_H_W-1:0];
        default:          fw_nxt = fw_r;
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (cmd.step) begin
      if (!cmd.src_flush && pix_last) begin
        col_nxt  = '0;
        row_nxt  = ROW_W'(eff_h);
        pend_nxt = (eff_h >= CFG_H_W'(2)) ? PEND_W'(eff_w) + 1'b1 : PEND_W'(eff_w);
      end else if (col_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else if (cmd.out_load && cmd.is_flush) begin
      pend_nxt = pend_r - 1'b1;
      if (pend_r == PEND_W'(1)) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= CFG_W_W'(1024);
      fh_r        <= CFG_H_W'(768);
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      win_r       <= '{default: '0};
    end else begin
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
    if (cmd.load_in) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (cmd.step || cmd.repl) begin
      ax_r <= (px >= nx) ? px - nx : nx - px;
      ay_r <= (py >= ny) ? py - ny : ny - py;
    end
    if (cmd.sq_x) begin
      rad_r <= RAD_W'(ax_sq);
    end
    if (cmd.out_load) begin
      out_mag_r  <= (root[ROOT_W-1:16] != '0) ? 8'hFF : root[15:8];
      out_last_r <= cmd.is_flush && (pend_r == PEND_W'(1));
    end
  end

  assign status.pend_zero = (pend_r == '0);
  assign status.emit      = col_zero ? (row_r >= ROW_W'(2)) : (row_r != '0);
  assign status.repl_case = row_r > ROW_W'(eff_h);
  assign status.sq_busy   = sq_busy;
  assign status.slot_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_magnitude     = out_mag_r;
  assign out_last_of_frame = out_last_r;

endmodule

@@ rtl/core/rsem_ctrl.sv @@
// Controller: sequences one pixel or flush transfer through the datapath.
module rsem_ctrl
  import rsem_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_operation,
  output logic         in_stall,
  input  rsem_status_t status,
  output rsem_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROC, ST_FLUSH, ST_FL_WAIT, ST_SQX, ST_SQY, ST_ROOT, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r;
  logic   flush_r, flush_nxt;
  logic   accept;

  assign accept = in_valid && !stall_r && (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    flush_nxt     = flush_r;
    cmd           = '0;
    cmd.is_flush  = flush_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in = accept;
        if (accept) begin
          flush_nxt = (in_operation == OP_FLUSH);
          if (in_operation == OP_FLUSH) begin
            if (!status.pend_zero) state_nxt = ST_FLUSH;
          end else begin
            if (status.pend_zero) state_nxt = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        cmd.step  = 1'b1;
        state_nxt = status.emit ? ST_SQX : ST_IDLE;
      end
      ST_FLUSH: begin
        if (status.repl_case) begin
          cmd.repl  = 1'b1;
          state_nxt = ST_SQX;
        end else begin
          cmd.step      = 1'b1;
          cmd.src_flush = 1'b1;
          state_nxt     = status.emit ? ST_SQX : ST_FL_WAIT;
        end
      end
      // column moved on: wait for the line store read
      ST_FL_WAIT: state_nxt = ST_FLUSH;
      ST_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (!status.sq_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stall_r <= 1'b1;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= (state_nxt != ST_IDLE);
      flush_r <= flush_nxt;
    end
  end

  assign in_stall = stall_r;

endmodule

@@ test/rgb_sobel_edge_magnitude_chk.sv @@
// Checker for the RGB Sobel edge magnitude block: edge predictor and result comparison.
`timescale 1ns / 100ps
module rgb_sobel_edge_magnitude_chk
  import rsem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_operation,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_magnitude,
  input  logic                 out_last_of_frame,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]   cfg_wdata,
  output int                   fail_count,
  output int                   edges_waiting,
  output int                   edges_checked
);

  typedef struct packed {
    logic [7:0] magnitude;
    logic       last;
  } edge_px_t;

  edge_px_t    edge_q[$];

  // Shadow of the block's state
  logic [15:0] gray_row1 [MAX_WIDTH];
  logic [15:0] gray_row2 [MAX_WIDTH];
  logic [15:0] win [9];
  int unsigned width_reg, height_reg;
  int unsigned col_pos, row_pos, flush_left;

  function automatic int unsigned used_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] sobel_mag();
    longint      gx, gy;
    logic [63:0] sq, rt;
    gx = longint'(win[2]) - longint'(win[0]) + 2 * (longint'(win[5]) - longint'(win[3]))
       + longint'(win[8]) - longint'(win[6]);
    gy = longint'(win[6]) - longint'(win[0]) + 2 * (longint'(win[7]) - longint'(win[1]))
       + longint'(win[8]) - longint'(win[2]);
    sq = gx * gx + gy * gy;
    rt = int_sqrt(sq) >> 8;
    return (rt > 255) ? 8'd255 : rt[7:0];
  endfunction

  function automatic void win_shift(logic [15:0] t, logic [15:0] m, logic [15:0] b);
    logic [15:0] colv [3];
    colv[0] = t; colv[1] = m; colv[2] = b;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
      win[r*3+2] = colv[r];
    end
  endfunction

  // Push one gray value through the line stores and window
  function automatic bit take_gray(logic [15:0] g, output logic [7:0] mag);
    int unsigned c, r;
    logic [15:0] t, m;
    bit          got;
    got = 0;
    mag = 0;
    c = col_pos & (MAX_WIDTH - 1);
    r = row_pos;
    if (c >= used_width()) c = 0;
    if (r == 0) begin
      t = g; m = g;
    end else if (r == 1) begin
      t = gray_row1[c]; m = gray_row1[c];
    end else begin
      t = gray_row2[c]; m = gray_row1[c];
    end
    gray_row2[c] = gray_row1[c];
    gray_row1[c] = g;
    if (c == 0) begin
      if (r >= 2) begin
        win_shift(win[2], win[5], win[8]);
        mag = sobel_mag();
        got = 1;
      end
      repeat (3) win_shift(t, m, g);
    end else begin
      win_shift(t, m, g);
      if (r >= 1) begin
        mag = sobel_mag();
        got = 1;
      end
    end
    col_pos++;
    if (col_pos >= used_width()) begin
      col_pos = 0;
      row_pos++;
    end
    return got;
  endfunction

  function automatic void predict_edge(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, gsum;
    logic [7:0]  mag;
    bit          got, at_end;
    edge_px_t    px_item;
    w   = used_width();
    h   = used_height();
    got = 0;
    if (op == OP_PIXEL) begin
      if (flush_left != 0) return;  // dropped while outputs pending
      gsum   = (GRAY_R * r + GRAY_G * g + GRAY_B * b) >> 8;
      at_end = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      got    = take_gray(gsum[15:0], mag);
      if (at_end) begin
        flush_left = (h >= 2) ? w + 1 : w;
        col_pos    = 0;
        row_pos    = h;
      end
      if (got) begin
        px_item.magnitude = mag;
        px_item.last      = 1'b0;
        edge_q.insert(edge_q.size(), px_item);
      end
      return;
    end
    if (flush_left == 0) return;    // stray flush
    for (int k = 0; k < 3 && !got; k++) begin
      if (row_pos <= h) begin
        got = take_gray(gray_row1[col_pos & (MAX_WIDTH - 1)], mag);
      end else begin
        win_shift(win[2], win[5], win[8]);
        mag = sobel_mag();
        got = 1;
      end
    end
    flush_left--;
    px_item.magnitude = mag;
    px_item.last      = (flush_left == 0);
    edge_q.insert(edge_q.size(), px_item);
    if (flush_left == 0) begin
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    edges_checked = 0;
    edges_waiting = 0;
  end

  // Watch configuration, input and output transfers
  always @(posedge clk) begin
    edge_px_t want;
    if (!rst_n) begin
      width_reg  = 1024;
      height_reg = 768;
      col_pos    = 0;
      row_pos    = 0;
      flush_left = 0;
      foreach (win[i]) win[i] = 0;
      edge_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_wdata & 13'h7FF;
        else height_reg = cfg_wdata & 13'h1FFF;
        col_pos    = 0;
        row_pos    = 0;
        flush_left = 0;
      end
      if (in_valid && !in_stall) predict_edge(in_operation, in_red, in_green, in_blue);
      if (out_valid && !out_stall) begin
        edges_checked++;
        if (edge_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result magnitude %0d", out_magnitude));
        end else begin
          want = edge_q.pop_front();
          if (out_magnitude !== want.magnitude)
            report_mismatch($sformatf("magnitude %0d, expected %0d",
                                      out_magnitude, want.magnitude));
          if (out_last_of_frame !== want.last)
            report_mismatch($sformatf("last_of_frame %0b, expected %0b",
                                      out_last_of_frame, want.last));
        end
      end
    end
    edges_waiting = edge_q.size();
  end

endmodule

@@ test/rgb_sobel_edge_magnitude_tb.sv @@
// Top of the RGB Sobel edge magnitude testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module rgb_sobel_edge_magnitude_tb;
  import rsem_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [7:0]           in_red, in_green, in_blue;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_magnitude;
  logic                 out_last_of_frame;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_D_W-1:0]   cfg_wdata;

  int fail_count, edges_waiting, edges_checked;
  int pixels_sent, flushes_sent, frames_run;
  bit send_quiet, recv_quiet, long_hold_req;

  rgb_sobel_edge_magnitude i_dut (.*);

  rgb_sobel_edge_magnitude_chk i_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_red, .in_green, .in_blue,
    .out_valid, .out_stall, .out_magnitude, .out_last_of_frame,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .fail_count, .edges_waiting, .edges_checked
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random hold-off per transfer, one long stretch on request
  initial begin
    int  hold;
    bit  fired;
    hold      = 0;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      fired = out_valid && !out_stall;
      @(negedge clk);
      if (fired) begin
        if ($urandom_range(0, 40) == 0) recv_quiet = ~recv_quiet;
        hold = recv_quiet ? 0 : $urandom_range(0, 13);
      end
      if (long_hold_req) begin
        hold          = 400;
        long_hold_req = 0;
      end
      out_stall = (hold > 0);
      if (hold > 0) hold--;
    end
  end

  // One input transfer, after a random gap
  task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     = 1;
    in_operation = op;
    in_red       = r;
    in_green     = g;
    in_blue      = b;
    do @(posedge clk); while (in_stall);
    if (op == OP_PIXEL) pixels_sent++;
    else flushes_sent++;
  endtask

  task automatic send_pixel();
    logic [7:0] c [3];
    foreach (c[i]) begin
      case ($urandom_range(0, 7))
        0:       c[i] = 8'h00;
        1:       c[i] = 8'hFF;
        default: c[i] = 8'($urandom_range(0, 255));
      endcase
    end
    send_item(OP_PIXEL, c[0], c[1], c[2]);
  endtask

  // Write both registers once the block has drained
  task automatic set_frame(int unsigned w, int unsigned h);
    @(negedge clk);
    in_valid = 0;
    wait (edges_waiting == 0);
    repeat (60) @(negedge clk);
    cfg_wr_en = 1;
    cfg_index = REG_FRAME_WIDTH;
    cfg_wdata = CFG_D_W'(w);
    @(negedge clk);
    cfg_index = REG_FRAME_HEIGHT;
    cfg_wdata = CFG_D_W'(h);
    @(negedge clk);
    cfg_wr_en = 0;
    frames_run++;
  endtask

  // A frame with stray flushes and dropped pixels mixed in; at times cut short, and always at cap pixels
  task automatic run_frame(int unsigned wr, int unsigned hr, int unsigned cap);
    int unsigned w, h, n, pend;
    w = (wr < 1) ? 1 : (wr > MAX_WIDTH) ? MAX_WIDTH : wr;
    h = (hr < 1) ? 1 : (hr > MAX_HEIGHT) ? MAX_HEIGHT : hr;
    n = w * h;
    if (n > 4 && $urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
    if (n > cap) n = cap;
    set_frame(wr, hr);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    if (n < w * h) return;
    pend = (h >= 2) ? w + 1 : w;
    for (int unsigned i = 0; i < pend; i++) begin
      if ($urandom_range(0, 9) == 0) send_pixel();
      send_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
  endtask

  initial begin
    rst_n         = 0;
    in_valid      = 0;
    in_operation  = OP_PIXEL;
    in_red        = 0;
    in_green      = 0;
    in_blue       = 0;
    cfg_wr_en     = 0;
    cfg_index     = REG_FRAME_WIDTH;
    cfg_wdata     = 0;
    send_quiet    = 0;
    recv_quiet    = 0;
    long_hold_req = 0;
    pixels_sent   = 0;
    flushes_sent  = 0;
    frames_run    = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Directed: 3x3 frame of extreme colours, stray flush, pixel while pending
    set_frame(3, 3);
    send_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PIXEL, 8'hFF, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'hFF);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'h00);
    send_item(OP_PIXEL, 8'h00, 8'hFF, 8'hFF);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    // Single-row frame
    set_frame(4, 1);
    repeat (2) send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    repeat (2) send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    repeat (4) send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);

    // Register extremes, including clamped values; large frames are cut short
    run_frame(0, 0, 1);
    run_frame(2047, 2, 1100);
    run_frame(1, 8191, 20);
    run_frame(5, 0, 5);
    run_frame(1, 4096, 20);

    // Random small frames; one long output hold-off part way through
    while (pixels_sent + flushes_sent < 1700) begin
      if ($urandom_range(0, 3) == 0) send_quiet = ~send_quiet;
      if (frames_run == 16) long_hold_req = 1;
      run_frame($urandom_range(1, 8), $urandom_range(1, 6), 48);
    end

    @(negedge clk);
    in_valid = 0;
    wait (edges_waiting == 0);
    repeat (60) @(posedge clk);
    $display("Ran %0d frame settings; %0d results compared, %0d pixels, %0d flushes sent",
             frames_run, edges_checked, pixels_sent, flushes_sent);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rsem_pkg.sv
rtl/core/rsem_ram.sv
rtl/core/rsem_isqrt.sv
rtl/core/rsem_dp.sv
rtl/core/rsem_ctrl.sv
rtl/core/rgb_sobel_edge_magnitude.sv
test/rgb_sobel_edge_magnitude_chk.sv
test/rgb_sobel_edge_magnitude_tb.sv
